>>> src/vgu_pkg.sv
package vgu_pkg;

  // Default build values
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_COORD_WIDTH = 32;

  // Magnitude scaling window: radicands are normalised to just under 2^NORM_BITS
  localparam int NORM_BITS = 100;
  localparam int ROOT_BITS = NORM_BITS / 2;
  // Normalising shifter has J_BITS steps of 64, 32, ... 2 bit positions
  localparam int J_BITS    = 6;

  typedef enum logic [1:0] {
    FN_DIST   = 2'd0,
    FN_SQDIST = 2'd1,
    FN_NORM   = 2'd2,
    FN_COS    = 2'd3
  } func_t;

endpackage

>>> src/vgu_if.sv
// Request channel: operation and two vectors
interface vgu_in_if import vgu_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] a_z;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] b_z;

  modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

// Result channel
interface vgu_out_if import vgu_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] scalar_result;
  logic signed [COORD_WIDTH-1:0] unit_x;
  logic signed [COORD_WIDTH-1:0] unit_y;
  logic signed [COORD_WIDTH-1:0] unit_z;
  logic                          overflow;
  logic                          zero_length;

  modport source (output valid, scalar_result, unit_x, unit_y, unit_z, overflow, zero_length,
                  input ready);
  modport sink   (input valid, scalar_result, unit_x, unit_y, unit_z, overflow, zero_length,
                  output ready);
endinterface

>>> src/vgu_front.sv
// Front end: differences, products, sums of squares, dot product and
// magnitude normalisation. Five register stages.
module vgu_front import vgu_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [1:0]                    func,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] a_z,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] b_z,
  output logic                          out_valid,
  output logic [NORM_BITS-1:0]          rad_a,
  output logic [NORM_BITS-1:0]          rad_b,
  output logic [J_BITS-1:0]             ja,
  output logic [J_BITS-1:0]             jb,
  output logic [2*COORD_WIDTH+1:0]      dot_mag,
  output logic                          dot_neg,
  output logic                          zero_len,
  output logic [COORD_WIDTH-1:0]        sq_res,
  output logic                          sq_ovf,
  output func_t                         fn,
  output logic [COORD_WIDTH-1:0]        ax,
  output logic [COORD_WIDTH-1:0]        ay,
  output logic [COORD_WIDTH-1:0]        az
);

  localparam int C  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * C + 2;
  localparam int SW = 2 * C + 4;
  localparam int NB = NORM_BITS;
  localparam logic [C-1:0] MAXP = {1'b0, {(C-1){1'b1}}};

  // Valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  // Carried request fields
  func_t fn1_r, fn2_r, fn3_r, fn4_r, fn5_r;
  logic signed [C-1:0] a1_r [3];
  logic signed [C-1:0] b1_r [3];
  logic signed [C-1:0] a2_r [3];
  logic signed [C-1:0] a3_r [3];
  logic signed [C-1:0] a4_r [3];
  logic signed [C-1:0] a5_r [3];

  // Stage 2 products
  logic signed [C:0]     d2 [3];
  logic signed [2*C+1:0] dd_r [3];
  logic signed [2*C-1:0] aa_r [3];
  logic signed [2*C-1:0] bb_r [3];
  logic signed [2*C-1:0] ab_r [3];

  // Stage 3 sums
  logic [SW-1:0]        sd3_r;
  logic [PW-1:0]        sa3_r, sb3_r;
  logic signed [PW-1:0] dot3_r;

  // Stage 4
  logic [SW-1:0]     sqq;
  logic [C-1:0]      sq4_nxt, sq4_r, sq5_r;
  logic              sov4_nxt, sov4_r, sov5_r;
  logic [PW-1:0]     dm4_nxt, dm4_r, dm5_r;
  logic              dn4_r, dn5_r;
  logic              zl4_nxt, zl4_r, zl5_r;
  logic [NB-1:0]     sd4_r;
  logic [NB-1:0]     xa4_nxt, xb4_nxt, xa4_r, xb4_r;
  logic [J_BITS-1:0] ja4_nxt, jb4_nxt, ja4_r, jb4_r;

  // Stage 5
  logic [NB-1:0]     xa5_nxt, xb5_nxt, ra5_r, rb5_r;
  logic [J_BITS-1:0] ja5_nxt, jb5_nxt, ja5_r, jb5_r;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage 1: capture request
  always_ff @(posedge clk) begin
    if (en) begin
      fn1_r   <= func_t'(func);
      a1_r[0] <= a_x;
      a1_r[1] <= a_y;
      a1_r[2] <= a_z;
      b1_r[0] <= b_x;
      b1_r[1] <= b_y;
      b1_r[2] <= b_z;
    end
  end

  // Stage 2: exact differences and all products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d2[i] = {a1_r[i][C-1], a1_r[i]} - {b1_r[i][C-1], b1_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn2_r <= fn1_r;
      for (int i = 0; i < 3; i++) begin
        a2_r[i] <= a1_r[i];
        dd_r[i] <= d2[i] * d2[i];
        aa_r[i] <= a1_r[i] * a1_r[i];
        bb_r[i] <= b1_r[i] * b1_r[i];
        ab_r[i] <= a1_r[i] * b1_r[i];
      end
    end
  end

  // Stage 3: sums of squares and dot product
  always_ff @(posedge clk) begin
    if (en) begin
      fn3_r  <= fn2_r;
      a3_r   <= a2_r;
      sd3_r  <= SW'($unsigned(dd_r[0])) + SW'($unsigned(dd_r[1])) + SW'($unsigned(dd_r[2]));
      sa3_r  <= PW'($unsigned(aa_r[0])) + PW'($unsigned(aa_r[1])) + PW'($unsigned(aa_r[2]));
      sb3_r  <= PW'($unsigned(bb_r[0])) + PW'($unsigned(bb_r[1])) + PW'($unsigned(bb_r[2]));
      dot3_r <= PW'(ab_r[0]) + PW'(ab_r[1]) + PW'(ab_r[2]);
    end
  end

  // Stage 4: squared distance, flags, first half of normalising shift
  always_comb begin
    sqq      = sd3_r >> F;
    sov4_nxt = (sqq > SW'(MAXP));
    sq4_nxt  = sov4_nxt ? MAXP : sqq[C-1:0];
    dm4_nxt  = dot3_r[PW-1] ? PW'(-dot3_r) : PW'(dot3_r);
    case (fn3_r)
      FN_NORM: zl4_nxt = (sa3_r == '0);
      FN_COS:  zl4_nxt = (sa3_r == '0) || (sb3_r == '0);
      default: zl4_nxt = 1'b0;
    endcase
    xa4_nxt = NB'(sa3_r);
    xb4_nxt = NB'(sb3_r);
    ja4_nxt = '0;
    jb4_nxt = '0;
    for (int s = 0; s < 3; s++) begin
      if ((xa4_nxt >> (NB - (2 << (J_BITS - 1 - s)))) == '0) begin
        xa4_nxt = xa4_nxt << (2 << (J_BITS - 1 - s));
        ja4_nxt[J_BITS-1-s] = 1'b1;
      end
      if ((xb4_nxt >> (NB - (2 << (J_BITS - 1 - s)))) == '0) begin
        xb4_nxt = xb4_nxt << (2 << (J_BITS - 1 - s));
        jb4_nxt[J_BITS-1-s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn4_r  <= fn3_r;
      a4_r   <= a3_r;
      sq4_r  <= sq4_nxt;
      sov4_r <= sov4_nxt;
      dm4_r  <= dm4_nxt;
      dn4_r  <= dot3_r[PW-1];
      zl4_r  <= zl4_nxt;
      sd4_r  <= NB'(sd3_r);
      xa4_r  <= xa4_nxt;
      xb4_r  <= xb4_nxt;
      ja4_r  <= ja4_nxt;
      jb4_r  <= jb4_nxt;
    end
  end

  // Stage 5: second half of normalising shift, radicand select
  always_comb begin
    xa5_nxt = xa4_r;
    xb5_nxt = xb4_r;
    ja5_nxt = ja4_r;
    jb5_nxt = jb4_r;
    for (int s = 3; s < J_BITS; s++) begin
      if ((xa5_nxt >> (NB - (2 << (J_BITS - 1 - s)))) == '0) begin
        xa5_nxt = xa5_nxt << (2 << (J_BITS - 1 - s));
        ja5_nxt[J_BITS-1-s] = 1'b1;
      end
      if ((xb5_nxt >> (NB - (2 << (J_BITS - 1 - s)))) == '0) begin
        xb5_nxt = xb5_nxt << (2 << (J_BITS - 1 - s));
        jb5_nxt[J_BITS-1-s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn5_r  <= fn4_r;
      a5_r   <= a4_r;
      sq5_r  <= sq4_r;
      sov5_r <= sov4_r;
      dm5_r  <= dm4_r;
      dn5_r  <= dn4_r;
      zl5_r  <= zl4_r;
      ra5_r  <= (fn4_r == FN_DIST) ? sd4_r : xa5_nxt;
      rb5_r  <= xb5_nxt;
      ja5_r  <= ja5_nxt;
      jb5_r  <= jb5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign rad_a     = ra5_r;
  assign rad_b     = rb5_r;
  assign ja        = ja5_r;
  assign jb        = jb5_r;
  assign dot_mag   = dm5_r;
  assign dot_neg   = dn5_r;
  assign zero_len  = zl5_r;
  assign sq_res    = sq5_r;
  assign sq_ovf    = sov5_r;
  assign fn        = fn5_r;
  assign ax        = a5_r[0];
  assign ay        = a5_r[1];
  assign az        = a5_r[2];

endmodule

>>> src/vgu_sqrt.sv
// Pipelined integer square root, one root bit per stage, several lanes.
module vgu_sqrt import vgu_pkg::*; #(
  parameter int LANES = 2,
  parameter int TAG_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [NORM_BITS-1:0] rad [LANES],
  input  logic [TAG_W-1:0]     tag_in,
  output logic                 out_valid,
  output logic [ROOT_BITS-1:0] root [LANES],
  output logic [TAG_W-1:0]     tag_out
);

  localparam int NB = NORM_BITS;
  localparam int RB = ROOT_BITS;

  logic              v_r [RB];
  logic [TAG_W-1:0]  t_r [RB];
  logic [NB-1:0]     n_r [RB][LANES];
  logic [NB-1:0]     q_r [RB][LANES];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam logic [NB-1:0] BIT = NB'(1) << (2 * (RB - 1 - k));
    logic [NB-1:0]    n_in [LANES];
    logic [NB-1:0]    q_in [LANES];
    logic [NB-1:0]    trial [LANES];
    logic [NB-1:0]    n_nxt [LANES];
    logic [NB-1:0]    q_nxt [LANES];
    logic             v_in;
    logic [TAG_W-1:0] t_in;

    if (k == 0) begin : g_head
      always_comb begin
        v_in = in_valid;
        t_in = tag_in;
        for (int l = 0; l < LANES; l++) begin
          n_in[l] = rad[l];
          q_in[l] = '0;
        end
      end
    end else begin : g_body
      always_comb begin
        v_in = v_r[k-1];
        t_in = t_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          n_in[l] = n_r[k-1][l];
          q_in[l] = q_r[k-1][l];
        end
      end
    end

    // One digit: subtract trial if it fits
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = q_in[l] + BIT;
        if (n_in[l] >= trial[l]) begin
          n_nxt[l] = n_in[l] - trial[l];
          q_nxt[l] = (q_in[l] >> 1) + BIT;
        end else begin
          n_nxt[l] = n_in[l];
          q_nxt[l] = q_in[l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[k] <= t_in;
        for (int l = 0; l < LANES; l++) begin
          n_r[k][l] <= n_nxt[l];
          q_r[k][l] <= q_nxt[l];
        end
      end
    end
  end

  assign out_valid = v_r[RB-1];
  assign tag_out   = t_r[RB-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root[l] = q_r[RB-1][l][RB-1:0];
    end
  end

endmodule

>>> src/vgu_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// The quotient must fit in QB bits.
module vgu_div import vgu_pkg::*; #(
  parameter int LANES = 4,
  parameter int NW    = 118,
  parameter int DW    = 100,
  parameter int QB    = 18,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NW-1:0]    num [LANES],
  input  logic [DW-1:0]    den [LANES],
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [QB-1:0]    quo [LANES],
  output logic [TAG_W-1:0] tag_out
);

  logic             v_r [QB];
  logic [TAG_W-1:0] t_r [QB];
  logic [NW-1:0]    r_r [QB][LANES];
  logic [DW-1:0]    d_r [QB][LANES];
  logic [QB-1:0]    q_r [QB][LANES];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [NW-1:0]    r_in [LANES];
    logic [DW-1:0]    d_in [LANES];
    logic [QB-1:0]    q_in [LANES];
    logic [NW-1:0]    cmp [LANES];
    logic [NW-1:0]    r_nxt [LANES];
    logic [QB-1:0]    q_nxt [LANES];
    logic             v_in;
    logic [TAG_W-1:0] t_in;

    if (k == 0) begin : g_head
      always_comb begin
        v_in = in_valid;
        t_in = tag_in;
        for (int l = 0; l < LANES; l++) begin
          r_in[l] = num[l];
          d_in[l] = den[l];
          q_in[l] = '0;
        end
      end
    end else begin : g_body
      always_comb begin
        v_in = v_r[k-1];
        t_in = t_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          r_in[l] = r_r[k-1][l];
          d_in[l] = d_r[k-1][l];
          q_in[l] = q_r[k-1][l];
        end
      end
    end

    // Trial subtract of the shifted divisor
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        cmp[l] = NW'(d_in[l]) << SH;
        if (r_in[l] >= cmp[l]) begin
          r_nxt[l] = r_in[l] - cmp[l];
          q_nxt[l] = q_in[l] | (QB'(1) << SH);
        end else begin
          r_nxt[l] = r_in[l];
          q_nxt[l] = q_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[k] <= t_in;
        for (int l = 0; l < LANES; l++) begin
          r_r[k][l] <= r_nxt[l];
          d_r[k][l] <= d_in[l];
          q_r[k][l] <= q_nxt[l];
        end
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign tag_out   = t_r[QB-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = q_r[QB-1][l];
    end
  end

endmodule

>>> src/vector3_geometry_unit.sv
// 3D vector geometry unit: distance, squared distance, normalise, cosine.
//
// in_req carries one request (func, vector a, vector b, signed Q16.16) with a
// valid/ready handshake; out_res returns exactly one result per request, in
// order, with the same handshake.
// An accepted request reaches out_res through five front stages, 50 square
// root stages, two magnitude product stages, FRAC_BITS + 2 divider stages and
// the output buffer. By default the square root pipeline is the deepest of
// these. Throughput is one request per cycle while the output buffer has room.
// Results land in a two-entry output buffer. The pipeline keeps accepting
// while one result waits; when both entries are full every stage holds and
// in_req.ready drops until the receiver takes a result.
// Reset (synchronous, active low) empties the buffer and clears all stage
// valid bits; in-flight requests are dropped.
module vector3_geometry_unit import vgu_pkg::*; #(
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input logic     clk,
  input logic     rst_n,
  vgu_in_if.sink  in_req,
  vgu_out_if.source out_res
);

  localparam int C   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * C + 2;
  localparam int RB  = ROOT_BITS;
  localparam int H   = RB / 2;
  localparam int QB  = F + 2;
  localparam int DDW = 2 * RB;
  localparam int NW  = DDW + QB;
  localparam int XW  = (RB > C ? RB : C) + 1;
  localparam logic [QB-1:0] ONE = QB'(1) << F;

  typedef struct packed {
    func_t             fn;
    logic [C-1:0]      ax;
    logic [C-1:0]      ay;
    logic [C-1:0]      az;
    logic              zl;
    logic              dneg;
    logic [PW-1:0]     dm;
    logic [J_BITS-1:0] ja;
    logic [J_BITS-1:0] jb;
    logic [C-1:0]      sq_res;
    logic              sq_ovf;
  } tag_t;

  typedef struct packed {
    tag_t          base;
    logic [RB-1:0] root0;
  } tag2_t;

  typedef struct packed {
    logic [C-1:0] scalar;
    logic [C-1:0] ux;
    logic [C-1:0] uy;
    logic [C-1:0] uz;
    logic         ovf;
    logic         zl;
  } res_t;

  // Saturate a magnitude with sign to C bits; top bit is the saturation flag
  function automatic logic [C:0] sat_val(input logic [XW-1:0] mag, input logic neg);
    logic [XW-1:0] lim;
    logic [XW-1:0] m;
    logic          ovf;
    lim = neg ? (XW'(1) << (C - 1)) : ((XW'(1) << (C - 1)) - XW'(1));
    ovf = (mag > lim);
    m   = ovf ? lim : mag;
    sat_val = {ovf, neg ? C'(-m) : C'(m)};
  endfunction

  logic en;
  logic push;
  logic pop;

  // Front end
  logic                  fr_v;
  logic [NORM_BITS-1:0]  rad [2];
  tag_t                  fr_tag;

  vgu_front #(
    .COORD_WIDTH (C),
    .FRAC_BITS   (F)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_req.valid),
    .func      (in_req.func),
    .a_x       (in_req.a_x),
    .a_y       (in_req.a_y),
    .a_z       (in_req.a_z),
    .b_x       (in_req.b_x),
    .b_y       (in_req.b_y),
    .b_z       (in_req.b_z),
    .out_valid (fr_v),
    .rad_a     (rad[0]),
    .rad_b     (rad[1]),
    .ja        (fr_tag.ja),
    .jb        (fr_tag.jb),
    .dot_mag   (fr_tag.dm),
    .dot_neg   (fr_tag.dneg),
    .zero_len  (fr_tag.zl),
    .sq_res    (fr_tag.sq_res),
    .sq_ovf    (fr_tag.sq_ovf),
    .fn        (fr_tag.fn),
    .ax        (fr_tag.ax),
    .ay        (fr_tag.ay),
    .az        (fr_tag.az)
  );

  // Square roots: lane 0 distance or |a| scaled, lane 1 |b| scaled
  logic          sq_v;
  logic [RB-1:0] root [2];
  tag_t          sq_tag;

  vgu_sqrt #(
    .LANES (2),
    .TAG_W ($bits(tag_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_v),
    .rad       (rad),
    .tag_in    (fr_tag),
    .out_valid (sq_v),
    .root      (root),
    .tag_out   (sq_tag)
  );

  // Magnitude product, stage 1: partial products
  logic          m1_v_r;
  tag_t          m1_tag_r;
  logic [RB-1:0] ma_r;
  logic [2*H-1:0] hh_r, hl_r, lh_r, ll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_tag_r <= sq_tag;
      ma_r     <= root[0];
      hh_r     <= root[0][RB-1:H] * root[1][RB-1:H];
      hl_r     <= root[0][RB-1:H] * root[1][H-1:0];
      lh_r     <= root[0][H-1:0] * root[1][RB-1:H];
      ll_r     <= root[0][H-1:0] * root[1][H-1:0];
    end
  end

  // Stage 2: product sum, numerators and divisors
  logic          m2_v_r;
  tag2_t         m2_tag_r;
  logic [NW-1:0] num_r [4];
  logic [DDW-1:0] den_r [4];
  logic [C-1:0]  amag [3];

  always_comb begin
    amag[0] = m1_tag_r.ax[C-1] ? C'(-m1_tag_r.ax) : m1_tag_r.ax;
    amag[1] = m1_tag_r.ay[C-1] ? C'(-m1_tag_r.ay) : m1_tag_r.ay;
    amag[2] = m1_tag_r.az[C-1] ? C'(-m1_tag_r.az) : m1_tag_r.az;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_tag_r.base  <= m1_tag_r;
      m2_tag_r.root0 <= ma_r;
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= NW'(amag[i]) << (F + m1_tag_r.ja);
        den_r[i] <= DDW'(ma_r);
      end
      num_r[3] <= NW'(m1_tag_r.dm) << (F + m1_tag_r.ja + m1_tag_r.jb);
      den_r[3] <= (DDW'(hh_r) << (2 * H)) + ((DDW'(hl_r) + DDW'(lh_r)) << H) + DDW'(ll_r);
    end
  end

  // Dividers: three unit components and the cosine
  logic          dv_v;
  logic [QB-1:0] quo [4];
  tag2_t         dv_tag;

  vgu_div #(
    .LANES (4),
    .NW    (NW),
    .DW    (DDW),
    .QB    (QB),
    .TAG_W ($bits(tag2_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m2_v_r),
    .num       (num_r),
    .den       (den_r),
    .tag_in    (m2_tag_r),
    .out_valid (dv_v),
    .quo       (quo),
    .tag_out   (dv_tag)
  );

  // Result formatting
  res_t          fmt;
  logic [C:0]    sv0, sv1, sv2, sv3;
  logic [QB-1:0] qc;

  always_comb begin
    fmt = '0;
    sv0 = '0;
    sv1 = '0;
    sv2 = '0;
    sv3 = '0;
    qc  = (quo[3] > ONE) ? ONE : quo[3];
    case (dv_tag.base.fn)
      FN_DIST: begin
        sv0        = sat_val(XW'(dv_tag.root0), 1'b0);
        fmt.scalar = sv0[C-1:0];
        fmt.ovf    = sv0[C];
      end
      FN_SQDIST: begin
        fmt.scalar = dv_tag.base.sq_res;
        fmt.ovf    = dv_tag.base.sq_ovf;
      end
      FN_NORM: begin
        if (dv_tag.base.zl) begin
          fmt.ux = dv_tag.base.ax;
          fmt.uy = dv_tag.base.ay;
          fmt.uz = dv_tag.base.az;
        end else begin
          sv1    = sat_val(XW'(quo[0]), dv_tag.base.ax[C-1]);
          sv2    = sat_val(XW'(quo[1]), dv_tag.base.ay[C-1]);
          sv3    = sat_val(XW'(quo[2]), dv_tag.base.az[C-1]);
          fmt.ux = sv1[C-1:0];
          fmt.uy = sv2[C-1:0];
          fmt.uz = sv3[C-1:0];
        end
      end
      FN_COS: begin
        if (!dv_tag.base.zl) begin
          sv0        = sat_val(XW'(qc), dv_tag.base.dneg && (qc != '0));
          fmt.scalar = sv0[C-1:0];
          fmt.ovf    = sv0[C];
        end
      end
      default: ;
    endcase
    fmt.zl = dv_tag.base.zl;
  end

  // Two-entry output buffer
  logic [1:0] cnt_r, cnt_nxt;
  res_t       s0_r, s1_r, s0_nxt, s1_nxt;

  assign en   = (cnt_r != 2'd2);
  assign push = en && dv_v;
  assign pop  = (cnt_r != 2'd0) && out_res.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    if (push && pop) begin
      s0_nxt = fmt;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        s0_nxt = fmt;
      end else begin
        s1_nxt = fmt;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop) begin
      s0_nxt  = s1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  assign in_req.ready          = en;
  assign out_res.valid         = (cnt_r != 2'd0);
  assign out_res.scalar_result = s0_r.scalar;
  assign out_res.unit_x        = s0_r.ux;
  assign out_res.unit_y        = s0_r.uy;
  assign out_res.unit_z        = s0_r.uz;
  assign out_res.overflow      = s0_r.ovf;
  assign out_res.zero_length   = s0_r.zl;

  // A saturated scalar comes only from scalar operations: units are zero
  // and the value sits at a rail
  a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.overflow |->
      out_res.unit_x == '0 && out_res.unit_y == '0 && out_res.unit_z == '0 &&
      (s0_r.scalar == {1'b0, {(C-1){1'b1}}} || s0_r.scalar == {1'b1, {(C-1){1'b0}}}))
    else $error("overflow result not at a rail or with unit vector");

  // Zero-length results never saturate
  a_zl_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.zero_length |-> !out_res.overflow)
    else $error("zero length with overflow");

  // A request written into an empty buffer is the next one shown
  a_buf_head: assert property (@(posedge clk) disable iff (!rst_n)
    push && cnt_r == 2'd0 |=> s0_r == $past(fmt) && out_res.valid)
    else $error("output buffer head lost");

endmodule
